// ===== src/rgb2hsv_pkg.sv =====
// ============================================================================
// RGB to HSV conversion package
// Shared widths, constants, payload types and the divider step used by the
// hexcone RGB to HSV converter.
// ============================================================================
package rgb2hsv_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int HUE_W        = 12;
  localparam int SAT_W        = 8;
  localparam int BRIGHT_W     = 8;

  // The quotient never reaches 4096, so both dividers resolve HUE_W bits.
  localparam int QUO_W      = HUE_W;
  localparam int DEN_W      = CHANNEL_BITS + 1;
  localparam int DIV_W      = CHANNEL_BITS + 13;
  localparam int HN_W       = DIV_W + 1;
  localparam int DIV_STAGES = QUO_W;
  localparam int LATENCY    = DIV_STAGES + 4;

  localparam int HUE_FULL   = 3600;
  localparam int HUE_SIXTH  = 600;
  localparam int SAT_SCALE  = 510;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]    hue;
    logic [SAT_W-1:0]    saturation;
    logic [BRIGHT_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic                valid;
    div_lane_t           hue;
    div_lane_t           sat;
    logic [BRIGHT_W-1:0] bright;
    logic                grey;
    logic                black;
  } div_stage_t;

  // One restoring division step: resolves the quotient bit of weight 2**bitpos
  // and shifts it into the quotient from the right.
  function automatic div_lane_t div_step(input div_lane_t lane, input int unsigned bitpos);
    logic [DIV_W-1:0] shifted;
    div_lane_t        res;
    begin
      shifted = DIV_W'(lane.den) << bitpos;
      res     = lane;
      if (lane.rem >= shifted) begin
        res.rem = lane.rem - shifted;
        res.quo = {lane.quo[QUO_W-2:0], 1'b1};
      end else begin
        res.quo = {lane.quo[QUO_W-2:0], 1'b0};
      end
      return res;
    end
  endfunction

endpackage

// ===== src/rgb_to_hsv_convert_top.sv =====
// ============================================================================
// RGB to HSV converter, hexcone model
// Converts one pixel of three channels to hue in tenths of a degree,
// saturation and value, through a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage: drive pixel and raise start; a pixel is taken at every rising edge
// at which start is high and busy is low. busy stays low, so one pixel can be
// taken in every cycle.
// Each result is presented on result for exactly one cycle with done high.
// The result of a pixel passes through three front stages (extremes,
// products, numerators), twelve divider stages that each resolve one
// quotient bit for hue and saturation together, and one output register.
// Throughput is one pixel per clock.
// Results leave in the order the pixels came in.
// Reset clears every valid bit, so pixels in flight are dropped and no done
// strobe follows reset until new pixels are taken. The receiver cannot hold
// results off; there is no stall path.
// ============================================================================
module rgb_to_hsv_convert_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rgb2hsv_pkg::pixel_t pixel,
  output logic                done,
  output rgb2hsv_pkg::hsv_t   result
);

  import rgb2hsv_pkg::*;

  typedef struct packed {
    logic                    valid;
    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] delta;
    sector_t                 sect;
    logic signed [CHANNEL_BITS:0] diff;
  } front_t;

  typedef struct packed {
    logic                    valid;
    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] delta;
    logic [DIV_W-1:0]        sat_num;
    logic signed [HN_W-1:0]  hue_n;
  } prod_t;

  localparam logic signed [HN_W-1:0] HUE_SIXTH_S = HN_W'(HUE_SIXTH);
  localparam logic signed [HN_W-1:0] HUE_FULL_S  = HN_W'(HUE_FULL);
  localparam logic [DIV_W-1:0]       SAT_SCALE_U = DIV_W'(SAT_SCALE);
  localparam logic [HUE_W-1:0]       HUE_FULL_U  = HUE_W'(HUE_FULL);

  front_t     front;
  front_t     front_next;
  prod_t      prod;
  prod_t      prod_next;
  div_stage_t pipe [DIV_STAGES+1];
  div_stage_t pipe0_next;
  hsv_t       result_next;

  logic                    accept;
  logic [CHANNEL_BITS-1:0] mx;
  logic [CHANNEL_BITS-1:0] mn;

  logic signed [HN_W-1:0] delta_s;
  logic signed [HN_W-1:0] diff_s;
  logic signed [HN_W-1:0] off_s;
  logic signed [HN_W-1:0] hue_pos;
  logic signed [HN_W-1:0] hue_num;
  logic [HUE_W-1:0]       hue_quo;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage one: extremes, delta, sector and channel difference.
  always_comb begin
    mx = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;

    front_next.valid = accept;
    front_next.mx    = mx;
    front_next.delta = mx - mn;
    priority if (mx == pixel.red) begin
      front_next.sect = SECT_RED;
      front_next.diff = signed'({1'b0, pixel.green}) - signed'({1'b0, pixel.blue});
    end else if (mx == pixel.green) begin
      front_next.sect = SECT_GREEN;
      front_next.diff = signed'({1'b0, pixel.blue}) - signed'({1'b0, pixel.red});
    end else begin
      front_next.sect = SECT_BLUE;
      front_next.diff = signed'({1'b0, pixel.red}) - signed'({1'b0, pixel.green});
    end
  end

  // Stage two: scaled numerators for saturation and hue.
  always_comb begin
    delta_s = signed'(HN_W'(front.delta));
    diff_s  = HN_W'(front.diff);
    unique case (front.sect)
      SECT_RED:   off_s = '0;
      SECT_GREEN: off_s = HUE_SIXTH_S * HN_W'(2);
      SECT_BLUE:  off_s = HUE_SIXTH_S * HN_W'(4);
      default:    off_s = '0;
    endcase

    prod_next.valid   = front.valid;
    prod_next.mx      = front.mx;
    prod_next.delta   = front.delta;
    prod_next.sat_num = SAT_SCALE_U * DIV_W'(front.delta) + DIV_W'(front.mx);
    prod_next.hue_n   = off_s * delta_s + HUE_SIXTH_S * diff_s;
  end

  // Stage three: fold negative hue into range and add the rounding term.
  always_comb begin
    if (prod.hue_n < 0) begin
      hue_pos = prod.hue_n + HUE_FULL_S * signed'(HN_W'(prod.delta));
    end else begin
      hue_pos = prod.hue_n;
    end
    hue_num = (hue_pos <<< 1) + signed'(HN_W'(prod.delta));

    pipe0_next.valid   = prod.valid;
    pipe0_next.hue.rem = hue_num[DIV_W-1:0];
    pipe0_next.hue.den = {prod.delta, 1'b0};
    pipe0_next.hue.quo = '0;
    pipe0_next.sat.rem = prod.sat_num;
    pipe0_next.sat.den = {prod.mx, 1'b0};
    pipe0_next.sat.quo = '0;
    pipe0_next.bright  = BRIGHT_W'(prod.mx);
    pipe0_next.grey    = (prod.delta == '0);
    pipe0_next.black   = (prod.mx == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid    <= 1'b0;
      prod.valid     <= 1'b0;
      pipe[0].valid  <= 1'b0;
    end else begin
      front.valid    <= front_next.valid;
      prod.valid     <= prod_next.valid;
      pipe[0].valid  <= pipe0_next.valid;
    end
    front.mx      <= front_next.mx;
    front.delta   <= front_next.delta;
    front.sect    <= front_next.sect;
    front.diff    <= front_next.diff;
    prod.mx       <= prod_next.mx;
    prod.delta    <= prod_next.delta;
    prod.sat_num  <= prod_next.sat_num;
    prod.hue_n    <= prod_next.hue_n;
    pipe[0].hue    <= pipe0_next.hue;
    pipe[0].sat    <= pipe0_next.sat;
    pipe[0].bright <= pipe0_next.bright;
    pipe[0].grey   <= pipe0_next.grey;
    pipe[0].black  <= pipe0_next.black;
  end

  // Divider stages: each resolves one quotient bit, most significant first.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1].valid <= 1'b0;
      end else begin
        pipe[k+1].valid <= pipe[k].valid;
      end
      pipe[k+1].hue    <= div_step(pipe[k].hue, DIV_STAGES - 1 - k);
      pipe[k+1].sat    <= div_step(pipe[k].sat, DIV_STAGES - 1 - k);
      pipe[k+1].bright <= pipe[k].bright;
      pipe[k+1].grey   <= pipe[k].grey;
      pipe[k+1].black  <= pipe[k].black;
    end
  end

  // Output stage: wrap a full circle to zero and apply the grey and black cases.
  always_comb begin
    hue_quo = pipe[DIV_STAGES].hue.quo;
    if (pipe[DIV_STAGES].grey) begin
      result_next.hue = '0;
    end else if (hue_quo >= HUE_FULL_U) begin
      result_next.hue = hue_quo - HUE_FULL_U;
    end else begin
      result_next.hue = hue_quo;
    end
    if (pipe[DIV_STAGES].black) begin
      result_next.saturation = '0;
    end else begin
      result_next.saturation = pipe[DIV_STAGES].sat.quo[SAT_W-1:0];
    end
    result_next.brightness = pipe[DIV_STAGES].bright;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pipe[DIV_STAGES].valid;
    end
    result <= result_next;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("A taken pixel produced no result after the pipeline latency.");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst, LATENCY) |-> $past(accept, LATENCY))
    else $error("A result was strobed without a matching pixel transaction.");

  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.hue < HUE_FULL_U))
    else $error("Hue left the range of a full circle.");

  a_black : assert property (@(posedge clk) disable iff (rst)
    done && (result.brightness == '0) |-> (result.saturation == '0) && (result.hue == '0))
    else $error("A black pixel gave non-zero hue or saturation.");

  a_grey : assert property (@(posedge clk) disable iff (rst)
    done && (result.saturation == '0) |-> (result.hue == '0))
    else $error("A grey pixel gave a non-zero hue.");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the hexcone RGB to HSV converter
// A table of directed pixels (black, white, grey, the primaries and
// secondaries, tied maxima and small or patterned channels) is followed by
// random pixels. An integer model predicts every result not typed in the table.
// Results are matched in order against a queue of predicted HSV values, and
// the sender idles at random so that gaps fall on every pipeline stage.
// ============================================================================
module tb;
  import rgb2hsv_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RANDOM_PIXELS = 400;
  localparam int STALL_LIMIT   = 1000;
  localparam int NUM_DIRECTED  = 20;

  typedef struct packed {
    pixel_t px;
    logic   typed;
    hsv_t   want;
  } pixel_row_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  pixel_t pixel;
  logic   done;
  hsv_t   result;

  logic   want_typed;
  hsv_t   want_hsv;

  hsv_t       hsv_pending[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  pixel_row_t directed [NUM_DIRECTED];

  rgb_to_hsv_convert_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic hsv_t hexcone_of(pixel_t px);
    longint  r, g, b, top, bottom, delta, offs, diff, num, quo;
    sector_t sect;
    hsv_t    h;
    r      = px.red;
    g      = px.green;
    b      = px.blue;
    top    = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    delta = top - bottom;
    h = '0;
    h.brightness = BRIGHT_W'(top);
    if (top > 0)
      h.saturation = SAT_W'((SAT_SCALE * delta + top) / (2 * top));
    if (delta > 0) begin
      if (top == r) sect = SECT_RED;
      else if (top == g) sect = SECT_GREEN;
      else sect = SECT_BLUE;
      case (sect)
        SECT_RED: begin
          offs = 0;
          diff = g - b;
        end
        SECT_GREEN: begin
          offs = 2 * HUE_SIXTH;
          diff = b - r;
        end
        default: begin
          offs = 4 * HUE_SIXTH;
          diff = r - g;
        end
      endcase
      num = offs * delta + HUE_SIXTH * diff;
      if (num < 0) num += HUE_FULL * delta;
      quo = (num * 2 + delta) / (2 * delta);
      if (quo >= HUE_FULL) quo -= HUE_FULL;
      h.hue = HUE_W'(quo);
    end
    return h;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     mode;
    int     full;
    full = (1 << CHANNEL_BITS) - 1;
    mode = $urandom_range(0, 9);
    px.red   = CHANNEL_BITS'($urandom);
    px.green = CHANNEL_BITS'($urandom);
    px.blue  = CHANNEL_BITS'($urandom);
    case (mode)
      5: begin
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue  = px.green;
          default: px.red = px.blue;
        endcase
      end
      6: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      7: begin
        px.red   = CHANNEL_BITS'($urandom_range(0, 3));
        px.green = CHANNEL_BITS'($urandom_range(0, 3));
        px.blue  = CHANNEL_BITS'($urandom_range(0, 3));
      end
      8: begin
        px.red   = $urandom_range(0, 1) ? CHANNEL_BITS'(full) : '0;
        px.green = $urandom_range(0, 1) ? CHANNEL_BITS'(full) : '0;
        px.blue  = $urandom_range(0, 1) ? CHANNEL_BITS'(full) : '0;
      end
      9: begin
        px.red   = CHANNEL_BITS'($urandom_range(full - 5, full));
        px.green = CHANNEL_BITS'($urandom_range(full - 5, full));
        px.blue  = CHANNEL_BITS'($urandom_range(full - 5, full));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Presents one pixel and returns at the edge at which the transaction is taken.
  task automatic drive_pixel(pixel_t px, logic typed, hsv_t want);
    start      <= 1'b1;
    pixel      <= px;
    want_typed <= typed;
    want_hsv   <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_after(bit allow_idle);
    while (allow_idle && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    hsv_t oldest;
    if (!rst) begin
      if (done) begin
        if (hsv_pending.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d with nothing pending",
                                    result.hue, result.saturation, result.brightness));
        end else begin
          oldest = hsv_pending.pop_front();
          if (result.hue !== oldest.hue)
            report_mismatch($sformatf("hue expected %0d, got %0d",
                                      oldest.hue, result.hue));
          if (result.saturation !== oldest.saturation)
            report_mismatch($sformatf("saturation expected %0d, got %0d",
                                      oldest.saturation, result.saturation));
          if (result.brightness !== oldest.brightness)
            report_mismatch($sformatf("brightness expected %0d, got %0d",
                                      oldest.brightness, result.brightness));
        end
      end
      if (start && !busy)
        hsv_pending = {hsv_pending, (want_typed ? want_hsv : hexcone_of(pixel))};
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    pixel        = '0;
    want_typed   = 1'b0;
    want_hsv     = '0;

    directed = '{
      '{{8'd0,   8'd0,   8'd0},   1'b1, {12'd0,    8'd0,   8'd0}},
      '{{8'd255, 8'd255, 8'd255}, 1'b1, {12'd0,    8'd0,   8'd255}},
      '{{8'd128, 8'd128, 8'd128}, 1'b1, {12'd0,    8'd0,   8'd128}},
      '{{8'd255, 8'd0,   8'd0},   1'b1, {12'd0,    8'd255, 8'd255}},
      '{{8'd0,   8'd255, 8'd0},   1'b1, {12'd1200, 8'd255, 8'd255}},
      '{{8'd0,   8'd0,   8'd255}, 1'b1, {12'd2400, 8'd255, 8'd255}},
      '{{8'd255, 8'd255, 8'd0},   1'b1, {12'd600,  8'd255, 8'd255}},
      '{{8'd0,   8'd255, 8'd255}, 1'b1, {12'd1800, 8'd255, 8'd255}},
      '{{8'd255, 8'd0,   8'd255}, 1'b1, {12'd3000, 8'd255, 8'd255}},
      '{{8'd1,   8'd0,   8'd0},   1'b0, '0},
      '{{8'd0,   8'd1,   8'd0},   1'b0, '0},
      '{{8'd0,   8'd0,   8'd1},   1'b0, '0},
      '{{8'd255, 8'd0,   8'd1},   1'b0, '0},
      '{{8'd254, 8'd255, 8'd253}, 1'b0, '0},
      '{{8'd1,   8'd2,   8'd3},   1'b0, '0},
      '{{8'd170, 8'd85,  8'd51},  1'b0, '0},
      '{{8'd85,  8'd170, 8'd204}, 1'b0, '0},
      '{{8'd200, 8'd100, 8'd150}, 1'b0, '0},
      '{{8'd10,  8'd200, 8'd30},  1'b0, '0},
      '{{8'd255, 8'd254, 8'd255}, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      drive_pixel(directed[i].px, directed[i].typed, directed[i].want);
      idle_after(1'b1);
    end

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      drive_pixel(random_pixel(), 1'b0, '0);
      if (n == 100) begin
        start <= 1'b0;
        while (hsv_pending.size() != 0) @(posedge clk);
      end else begin
        idle_after(n < 150 || n > 260);
      end
    end

    start <= 1'b0;
    while (hsv_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
